// ===== sv/tcpu_pkg.sv =====
// Shared constants and types for the teaching CPU execute unit.
`timescale 1ns / 1ps
`default_nettype none
package tcpu_pkg;

    localparam int MEM_WORDS = 32768;               // power of two
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int REG_COUNT = 8;
    localparam int RF_AW     = $clog2(REG_COUNT);
    localparam int XLEN      = 32;
    localparam int IPW       = 16;
    localparam int CNTW      = $clog2(XLEN);

    localparam logic [7:0] OP_HALT = 8'd0;
    localparam logic [7:0] OP_MOVE = 8'd1;
    localparam logic [7:0] OP_ADD  = 8'd2;
    localparam logic [7:0] OP_SUB  = 8'd3;
    localparam logic [7:0] OP_MUL  = 8'd4;
    localparam logic [7:0] OP_DIV  = 8'd5;
    localparam logic [7:0] OP_AND  = 8'd6;
    localparam logic [7:0] OP_OR   = 8'd7;
    localparam logic [7:0] OP_NOT  = 8'd8;
    localparam logic [7:0] OP_CMP  = 8'd9;
    localparam logic [7:0] OP_JMP  = 8'd10;
    localparam logic [7:0] OP_IN   = 8'd11;
    localparam logic [7:0] OP_OUT  = 8'd12;

    localparam logic [3:0] JC_ALWAYS = 4'd0;
    localparam logic [3:0] JC_EQ     = 4'd1;
    localparam logic [3:0] JC_GT     = 4'd2;
    localparam logic [3:0] JC_LT     = 4'd3;

    localparam logic [1:0] FLAG_EQ = 2'b00;
    localparam logic [1:0] FLAG_GT = 2'b01;
    localparam logic [1:0] FLAG_LT = 2'b11;

    localparam logic [IPW-1:0] IP_STEP = 16'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// ===== sv/teaching_cpu_execute_unit.sv =====
// Execute unit of an eight-register teaching CPU: sequencer, serial mul/div, data memory.
//
// Usage: one instruction (plus input_value) is taken per request on the in_* channel
// (in_valid / in_stall); one result per request leaves on the res_* channel
// (res_valid / res_stall). start_address is written through cfg_wr_en / cfg_wr_data.
// Sequence: an accepted instruction passes decode, execute and finish, and the result is
// registered when finish completes; a store, or any instruction after halt, skips execute.
// The data memory operand read overlaps decode. Multiply, and divide by a non-zero value,
// add a bit-serial shift-add / restoring loop between execute and finish.
// One instruction is in flight at a time; a new request is taken only in the idle state,
// after the previous one has left finish, which waits until the output register frees.
// Reset: registers, flag, ip and halt mark clear at once; afterwards a clearing pass
// writes zero to every data memory word, with in_stall held high.
// When the receiver stalls, the result waits in the output register; the next
// instruction is still accepted and worked on, and holds in its finish step until
// the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module teaching_cpu_execute_unit
    import tcpu_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [15:0]            cfg_wr_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [31:0]            instruction,
    input  wire logic signed [31:0]     input_value,
    output logic                        res_valid,
    input  wire logic                   res_stall,
    output logic [15:0]                 next_ip,
    output logic signed [1:0]           compare_flag,
    output logic [15:0]                 ir_high,
    output logic                        branch_taken,
    output logic                        out_valid,
    output logic signed [31:0]          out_value,
    output logic [3:0]                  dest_index,
    output logic signed [31:0]          dest_value,
    output logic                        halted,
    output logic                        divide_error
);

    state_t state_reg, state_next;

    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [IPW-1:0]    ip_reg;
    logic [1:0]        flag_reg;
    logic              halt_reg;
    logic              res_valid_reg;
    logic [15:0]       start_address_reg;

    logic [31:0]       ir_reg;
    logic [XLEN-1:0]   inval_reg;
    logic [XLEN-1:0]   a_reg;
    logic [XLEN-1:0]   sv_reg;
    logic              wr_reg;
    logic [XLEN-1:0]   wval_reg;
    logic              taken_reg;
    logic              ovalid_reg;
    logic              derr_reg;
    logic              skip_reg;
    logic [XLEN-1:0]   acc_reg;
    logic [XLEN-1:0]   mcand_reg;
    logic [XLEN-1:0]   mplier_reg;
    logic [XLEN-1:0]   rem_reg;
    logic [XLEN-1:0]   quo_reg;
    logic [XLEN-1:0]   dvsr_reg;
    logic              neg_reg;
    logic [CNTW-1:0]   cnt_reg;

    logic [IPW-1:0]    o_ip_reg;
    logic [1:0]        o_flag_reg;
    logic [15:0]       o_irh_reg;
    logic              o_taken_reg;
    logic              o_ovalid_reg;
    logic [XLEN-1:0]   o_oval_reg;
    logic [3:0]        o_didx_reg;
    logic [XLEN-1:0]   o_dval_reg;
    logic              o_halted_reg;
    logic              o_derr_reg;

    logic [XLEN-1:0]   rf_mem [REG_COUNT];
    logic [XLEN-1:0]   dmem [MEM_WORDS];
    logic [XLEN-1:0]   mem_q;

    logic              mem_we;
    logic              mem_re;
    logic [MEM_AW-1:0] mem_wa;
    logic [MEM_AW-1:0] mem_ra;
    logic [XLEN-1:0]   mem_wd;

    logic [7:0]        op;
    logic [3:0]        fd;
    logic [3:0]        fs;
    logic [XLEN-1:0]   imm_ext;
    logic [XLEN-1:0]   b_val;
    logic              d_ok;
    logic              is_store;
    logic              needs_rd;
    logic              in_acc;
    logic              can_out;
    logic              commit;
    logic [IPW-1:0]    nip;
    logic              flag_cond;
    logic [XLEN-1:0]   acc_next;
    logic [XLEN-1:0]   rem_shift;
    logic              rem_ge;
    logic [XLEN-1:0]   quo_next;
    logic [XLEN-1:0]   a_abs;
    logic [XLEN-1:0]   b_abs;

    assign op      = ir_reg[31:24];
    assign fd      = ir_reg[23:20];
    assign fs      = ir_reg[19:16];
    assign imm_ext = {{(XLEN-16){ir_reg[15]}}, ir_reg[15:0]};
    assign b_val   = (fs == 4'd0) ? imm_ext : mem_q;
    assign d_ok    = (fd != 4'd0) && (fd <= 4'(REG_COUNT));
    assign is_store = (op == OP_MOVE) && (fs != 4'd0) && (fs <= 4'd4);
    assign needs_rd = (fs != 4'd0) &&
                      ((op >= OP_ADD && op <= OP_NOT) || op == OP_CMP ||
                       (op == OP_MOVE && fs >= 4'd5));

    assign in_acc  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign can_out = !res_valid_reg || !res_stall;
    assign commit  = (state_reg == ST_FINISH) && can_out;

    assign nip = skip_reg  ? ip_reg :
                 taken_reg ? ip_reg + ir_reg[15:0] :
                             ip_reg + IP_STEP;

    assign acc_next  = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign rem_shift = {rem_reg[XLEN-2:0], quo_reg[XLEN-1]};
    assign rem_ge    = (rem_shift >= dvsr_reg);
    assign quo_next  = {quo_reg[XLEN-2:0], rem_ge};
    assign a_abs     = a_reg[XLEN-1] ? (~a_reg + 1'b1) : a_reg;
    assign b_abs     = b_val[XLEN-1] ? (~b_val + 1'b1) : b_val;

    always_comb
    begin
        case (fs)
            JC_ALWAYS: flag_cond = 1'b1;
            JC_EQ:     flag_cond = (flag_reg == FLAG_EQ);
            JC_GT:     flag_cond = (flag_reg == FLAG_GT);
            JC_LT:     flag_cond = (flag_reg == FLAG_LT);
            default:   flag_cond = 1'b0;
        endcase
    end

    // data memory port control
    always_comb
    begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = sv_reg[MEM_AW-1:0];
        mem_ra = sv_reg[MEM_AW-1:0];
        mem_wd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_cnt_reg;
            end
            ST_DECODE:
            begin
                if (!halt_reg && is_store)
                begin
                    mem_we = 1'b1;
                    mem_wa = a_reg[MEM_AW-1:0];
                    mem_wd = sv_reg;
                end
                mem_re = !halt_reg && needs_rd;
            end
            ST_EXEC:
            begin
                if (op == OP_NOT && fs != 4'd0)
                begin
                    mem_we = 1'b1;
                    mem_wd = {{(XLEN-1){1'b0}}, (mem_q == '0)};
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == MEM_AW'(MEM_WORDS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_acc)
                    state_next = ST_DECODE;
            ST_DECODE:
                if (halt_reg || is_store)
                    state_next = ST_FINISH;
                else
                    state_next = ST_EXEC;
            ST_EXEC:
                if (op == OP_MUL)
                    state_next = ST_MUL;
                else if (op == OP_DIV && b_val != '0)
                    state_next = ST_DIV;
                else
                    state_next = ST_FINISH;
            ST_MUL, ST_DIV:
                if (cnt_reg == '0)
                    state_next = ST_FINISH;
            ST_FINISH:
                if (can_out)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            ip_reg            <= '0;
            flag_reg          <= FLAG_EQ;
            halt_reg          <= 1'b0;
            res_valid_reg     <= 1'b0;
            start_address_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                start_address_reg <= cfg_wr_data;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == ST_EXEC && op == OP_CMP)
            begin
                if (a_reg == b_val)
                    flag_reg <= FLAG_EQ;
                else if ($signed(a_reg) > $signed(b_val))
                    flag_reg <= FLAG_GT;
                else
                    flag_reg <= FLAG_LT;
            end
            if (commit)
            begin
                ip_reg        <= nip;
                halt_reg      <= halt_reg || (!skip_reg && op == OP_HALT);
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                rf_mem[i] <= '0;
        end
        else if (commit && wr_reg)
            rf_mem[RF_AW'(fd - 4'd1)] <= wval_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            dmem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_q <= dmem[mem_ra];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    ir_reg    <= instruction;
                    inval_reg <= input_value;
                    a_reg     <= (instruction[23:20] != 4'd0 &&
                                  instruction[23:20] <= 4'(REG_COUNT))
                                 ? rf_mem[RF_AW'(instruction[23:20] - 4'd1)] : '0;
                    sv_reg    <= (instruction[19:16] != 4'd0 &&
                                  instruction[19:16] <= 4'(REG_COUNT))
                                 ? rf_mem[RF_AW'(instruction[19:16] - 4'd1)] : '0;
                end
            end
            ST_DECODE:
            begin
                wr_reg     <= 1'b0;
                wval_reg   <= '0;
                taken_reg  <= 1'b0;
                ovalid_reg <= 1'b0;
                derr_reg   <= 1'b0;
                skip_reg   <= halt_reg;
            end
            ST_EXEC:
            begin
                case (op)
                    OP_MOVE:
                    begin
                        wr_reg   <= d_ok;
                        wval_reg <= b_val;
                    end
                    OP_ADD:
                    begin
                        wr_reg   <= d_ok;
                        wval_reg <= a_reg + b_val;
                    end
                    OP_SUB:
                    begin
                        wr_reg   <= d_ok;
                        wval_reg <= a_reg - b_val;
                    end
                    OP_MUL:
                    begin
                        acc_reg    <= '0;
                        mcand_reg  <= a_reg;
                        mplier_reg <= b_val;
                        cnt_reg    <= CNTW'(XLEN - 1);
                    end
                    OP_DIV:
                    begin
                        if (b_val == '0)
                            derr_reg <= 1'b1;
                        rem_reg  <= '0;
                        quo_reg  <= a_abs;
                        dvsr_reg <= b_abs;
                        neg_reg  <= a_reg[XLEN-1] ^ b_val[XLEN-1];
                        cnt_reg  <= CNTW'(XLEN - 1);
                    end
                    OP_AND:
                    begin
                        wr_reg   <= d_ok;
                        wval_reg <= {{(XLEN-1){1'b0}}, (a_reg != '0 && b_val != '0)};
                    end
                    OP_OR:
                    begin
                        wr_reg   <= d_ok;
                        wval_reg <= {{(XLEN-1){1'b0}}, (a_reg != '0 || b_val != '0)};
                    end
                    OP_NOT:
                    begin
                        wr_reg   <= d_ok && (fs == 4'd0);
                        wval_reg <= {{(XLEN-1){1'b0}}, (a_reg == '0)};
                    end
                    OP_JMP:
                        taken_reg <= flag_cond;
                    OP_IN:
                    begin
                        wr_reg   <= d_ok;
                        wval_reg <= inval_reg;
                    end
                    OP_OUT:
                        ovalid_reg <= 1'b1;
                    default:
                        wr_reg <= 1'b0;
                endcase
            end
            ST_MUL:
            begin
                acc_reg    <= acc_next;
                mcand_reg  <= {mcand_reg[XLEN-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[XLEN-1:1]};
                cnt_reg    <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    wr_reg   <= d_ok;
                    wval_reg <= acc_next;
                end
            end
            ST_DIV:
            begin
                rem_reg <= rem_ge ? rem_shift - dvsr_reg : rem_shift;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    wr_reg   <= d_ok;
                    wval_reg <= neg_reg ? (~quo_next + 1'b1) : quo_next;
                end
            end
            ST_FINISH:
            begin
                if (can_out)
                begin
                    o_ip_reg     <= nip;
                    o_flag_reg   <= flag_reg;
                    o_irh_reg    <= ir_reg[31:16];
                    o_taken_reg  <= taken_reg;
                    o_ovalid_reg <= ovalid_reg;
                    o_oval_reg   <= ovalid_reg ? a_reg : '0;
                    o_didx_reg   <= wr_reg ? fd : 4'd0;
                    o_dval_reg   <= wr_reg ? wval_reg : '0;
                    o_halted_reg <= skip_reg || halt_reg || (op == OP_HALT);
                    o_derr_reg   <= derr_reg;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign res_valid    = res_valid_reg;
    assign next_ip      = o_ip_reg;
    assign compare_flag = o_flag_reg;
    assign ir_high      = o_irh_reg;
    assign branch_taken = o_taken_reg;
    assign out_valid    = o_ovalid_reg;
    assign out_value    = o_oval_reg;
    assign dest_index   = o_didx_reg;
    assign dest_value   = o_dval_reg;
    assign halted       = o_halted_reg;
    assign divide_error = o_derr_reg;

`ifndef ASSERT_OFF
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("request accepted during memory clear");

    a_dest_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (dest_index <= 4'(REG_COUNT)))
        else $error("destination index out of range");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && halted) |-> (dest_index == 4'd0 && !out_valid &&
                                   !branch_taken && !divide_error))
        else $error("halted result carries side effects");

    a_div_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && divide_error) |-> (dest_index == 4'd0))
        else $error("divide error with register write");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (commit) |=> res_valid)
        else $error("committed result not presented");
`endif

endmodule
`default_nettype wire
